/* rtl/pd_joint_trajectory_limiter_defines.svh */
// Assertion macros for the joint trajectory limiter.
// Depends on nothing; included by the top level before its module header.
`ifndef PD_JOINT_TRAJECTORY_LIMITER_DEFINES_SVH
`define PD_JOINT_TRAJECTORY_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDJTL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdjtl same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PDJTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdjtl next-cycle check failed");

`endif

/* rtl/pdjtl_pkg.sv */
// Shared types, constants, microprogram and helpers for the joint trajectory limiter.
// Depends on nothing; imported by pd_joint_trajectory_limiter.
package pdjtl_pkg;

	// Joint table size and the index width it needs.
	localparam int NUM_JOINTS = 5;
	localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	// Angle constants in Q4.12.
	localparam logic signed [16:0] PI_Q12     = 17'sd12868;
	localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

	// Configuration register indexes.
	localparam logic [2:0] REG_KP_GAIN   = 3'd0;
	localparam logic [2:0] REG_KD_GAIN   = 3'd1;
	localparam logic [2:0] REG_ACCEL_MAX = 3'd2;
	localparam logic [2:0] REG_DAMPING   = 3'd3;
	localparam logic [2:0] REG_VEL_MAX   = 3'd4;
	localparam logic [2:0] REG_STEP_TIME = 3'd5;

	// Configuration reset values.
	localparam logic [15:0] KP_GAIN_RST   = 16'd2560;
	localparam logic [15:0] KD_GAIN_RST   = 16'd1280;
	localparam logic [14:0] ACCEL_MAX_RST = 15'd6144;
	localparam logic [14:0] DAMPING_RST   = 15'd3072;
	localparam logic [14:0] VEL_MAX_RST   = 15'd6144;
	localparam logic [19:0] STEP_TIME_RST = 20'd16777;

	// Input and result transactions.
	typedef struct packed {
		logic [2:0]          joint;
		logic signed [15:0]  goal_angle;
		logic signed [15:0]  measured_angle;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          joint_out;
		logic signed [15:0]  next_position;
		logic signed [15:0]  next_velocity;
		logic                accel_limited;
		logic                vel_limited;
	} out_item_t;

	// Step counter.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_MUL_KP  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_MUL_KD  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_ACC_SUB = 4'd3;
	localparam logic [STEP_W-1:0] STEP_ACLAMP  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_DIFF    = 4'd5;
	localparam logic [STEP_W-1:0] STEP_MUL_DT  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_VEL     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_MUL_NV  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_POS     = 4'd9;

	// Multiplier operand A selects.
	localparam logic [1:0] A_ERR  = 2'd0;
	localparam logic [1:0] A_VEL  = 2'd1;
	localparam logic [1:0] A_DIFF = 2'd2;
	localparam logic [1:0] A_NV   = 2'd3;

	// Multiplier operand B selects.
	localparam logic [1:0] B_KP   = 2'd0;
	localparam logic [1:0] B_KD   = 2'd1;
	localparam logic [1:0] B_DAMP = 2'd2;
	localparam logic [1:0] B_STEP = 2'd3;

	// Datapath operations.
	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_LOAD    = 3'd1;
	localparam logic [2:0] OP_ACC_LD  = 3'd2;
	localparam logic [2:0] OP_ACC_SUB = 3'd3;
	localparam logic [2:0] OP_ACLAMP  = 3'd4;
	localparam logic [2:0] OP_DIFF    = 3'd5;
	localparam logic [2:0] OP_VEL     = 3'd6;
	localparam logic [2:0] OP_POS     = 3'd7;

	// Sequencing codes.
	localparam logic [1:0] BR_NEXT     = 2'd0;
	localparam logic [1:0] BR_WAIT_IN  = 2'd1;
	localparam logic [1:0] BR_WAIT_OUT = 2'd2;
	localparam logic [1:0] BR_JUMP     = 2'd3;

	// One control word of the microprogram.
	typedef struct packed {
		logic [1:0]        a_sel;
		logic [1:0]        b_sel;
		logic [2:0]        op;
		logic [1:0]        br;
		logic [STEP_W-1:0] target;
	} ucode_t;

	// Microprogram ROM. Products are registered and used in the step after selection.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{a_sel: A_VEL, b_sel: B_DAMP, op: OP_NONE, br: BR_JUMP, target: STEP_IDLE};
		case (step)
			STEP_IDLE:    w = '{A_ERR,  B_KP,   OP_LOAD,    BR_WAIT_IN,  STEP_IDLE};
			STEP_MUL_KP:  w = '{A_ERR,  B_KP,   OP_NONE,    BR_NEXT,     STEP_IDLE};
			STEP_MUL_KD:  w = '{A_VEL,  B_KD,   OP_ACC_LD,  BR_NEXT,     STEP_IDLE};
			STEP_ACC_SUB: w = '{A_VEL,  B_DAMP, OP_ACC_SUB, BR_NEXT,     STEP_IDLE};
			STEP_ACLAMP:  w = '{A_VEL,  B_DAMP, OP_ACLAMP,  BR_NEXT,     STEP_IDLE};
			STEP_DIFF:    w = '{A_DIFF, B_STEP, OP_DIFF,    BR_NEXT,     STEP_IDLE};
			STEP_MUL_DT:  w = '{A_DIFF, B_STEP, OP_NONE,    BR_NEXT,     STEP_IDLE};
			STEP_VEL:     w = '{A_NV,   B_STEP, OP_VEL,     BR_NEXT,     STEP_IDLE};
			STEP_MUL_NV:  w = '{A_NV,   B_STEP, OP_NONE,    BR_NEXT,     STEP_IDLE};
			STEP_POS:     w = '{A_NV,   B_STEP, OP_POS,     BR_WAIT_OUT, STEP_IDLE};
			default:      w = '{A_VEL,  B_DAMP, OP_NONE,    BR_JUMP,     STEP_IDLE};
		endcase
		return w;
	endfunction

	// Wrap a Q4.12 angle to [-pi, pi). One correction covers the whole 16-bit range.
	function automatic logic signed [15:0] wrap_angle(input logic signed [15:0] x);
		logic signed [16:0] xs;
		logic signed [16:0] r;
		xs = 17'(x);
		if (xs >= PI_Q12) begin
			r = xs - TWO_PI_Q12;
		end else if (xs < -PI_Q12) begin
			r = xs + TWO_PI_Q12;
		end else begin
			r = xs;
		end
		return r[15:0];
	endfunction

endpackage

/* rtl/pd_joint_trajectory_limiter.sv */
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  pdjtl_pkg::in_item_t (joint, goal, measured angle)
// out      out  out_valid/out_stall pdjtl_pkg::out_item_t (position, velocity, flags)
// cfg      in   cfg_we             cfg_index selects register, cfg_data carries value
//
// Each transaction runs through a ten-step microprogram, and every product passes
// through the single shared 33x21 multiplier; a new item is taken only in the idle step.
// A finished result sits in the output register, and the next item is taken meanwhile;
// the last step waits only if the previous result is still stalled there.
// Reset clears the sequencer, loads the register defaults and zeroes joint velocities.
//
// Top level of the joint trajectory limiter: PD acceleration, damped velocity
// integration and position step. Depends on pdjtl_pkg and the defines header.
`include "pd_joint_trajectory_limiter_defines.svh"

module pd_joint_trajectory_limiter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pdjtl_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pdjtl_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [19:0]          cfg_data
);
	import pdjtl_pkg::*;

	// Sequencer and configuration state.
	logic [STEP_W-1:0] step_q;
	ucode_t            uc;
	logic [15:0]       kp_q;
	logic [15:0]       kd_q;
	logic [14:0]       amax_q;
	logic [14:0]       damp_q;
	logic [14:0]       vmax_q;
	logic [19:0]       dt_q;
	logic signed [15:0] vel_q [NUM_JOINTS];

	// Per-item datapath registers.
	logic [2:0]         joint_q;
	logic               jvalid_q;
	logic signed [16:0] err_q;
	logic signed [15:0] meas_q;
	logic signed [15:0] v_q;
	logic signed [53:0] prod_q;
	logic signed [33:0] acc_q;
	logic signed [15:0] acc_lim_q;
	logic signed [15:0] nv_q;
	logic               alim_q;
	logic               vlim_q;
	logic               out_valid_q;
	out_item_t          out_q;

	// Combinational helpers.
	logic               in_acc;
	logic               out_busy;
	logic               pos_fire;
	logic               load_valid;
	logic signed [15:0] goal_w;
	logic signed [15:0] meas_w;
	logic signed [32:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [53:0] prod_d;
	logic signed [33:0] amax20;
	logic signed [17:0] vsum;
	logic signed [17:0] vmax18;
	logic signed [15:0] nv_d;
	logic               vlim_d;
	logic signed [17:0] psum;
	logic signed [15:0] pos_d;

	// The control word for the current step.
	assign uc = ucode_rom(step_q);

	// Handshakes.
	assign in_stall  = (uc.op != OP_LOAD);
	assign in_acc    = in_valid & ~in_stall;
	assign out_busy  = out_valid_q & out_stall;
	assign pos_fire  = (uc.op == OP_POS) & ~out_busy;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Input conditioning at load time.
	assign goal_w     = wrap_angle(in_data.goal_angle);
	assign meas_w     = wrap_angle(in_data.measured_angle);
	assign load_valid = ({2'b00, in_data.joint} < 5'(NUM_JOINTS));

	// Operand selection for the shared multiplier.
	always_comb begin
		case (uc.a_sel)
			A_ERR:   mul_a = 33'(err_q);
			A_VEL:   mul_a = 33'(v_q);
			A_DIFF:  mul_a = acc_q[32:0];
			A_NV:    mul_a = 33'(nv_q);
			default: mul_a = '0;
		endcase
		case (uc.b_sel)
			B_KP:    mul_b = $signed({5'b0, kp_q});
			B_KD:    mul_b = $signed({5'b0, kd_q});
			B_DAMP:  mul_b = $signed({6'b0, damp_q});
			B_STEP:  mul_b = $signed({1'b0, dt_q});
			default: mul_b = '0;
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// Acceleration limit at Q.20 precision.
	assign amax20 = $signed({11'b0, amax_q, 8'b0});

	// Velocity update: floor of the Q.48 step, then clamp to the limit.
	assign vmax18 = $signed({3'b0, vmax_q});
	assign vsum   = 18'(v_q) + 18'($signed(prod_q[52:36]));
	always_comb begin
		if (vsum > vmax18) begin
			nv_d   = vmax18[15:0];
			vlim_d = 1'b1;
		end else if (vsum < -vmax18) begin
			nv_d   = 16'(-vmax18);
			vlim_d = 1'b1;
		end else begin
			nv_d   = vsum[15:0];
			vlim_d = 1'b0;
		end
	end

	// Next position: floor of the Q.36 step, saturated to 16 bits.
	assign psum = 18'(meas_q) + $signed(prod_q[41:24]);
	always_comb begin
		if (psum > 18'sd32767) begin
			pos_d = 16'sh7FFF;
		end else if (psum < -18'sd32768) begin
			pos_d = 16'sh8000;
		end else begin
			pos_d = psum[15:0];
		end
	end

	// Step counter with conditional jumps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			case (uc.br)
				BR_NEXT: step_q <= step_q + 1'b1;
				BR_WAIT_IN: begin
					if (in_acc) step_q <= step_q + 1'b1;
				end
				BR_WAIT_OUT: begin
					if (!out_busy) step_q <= uc.target;
				end
				BR_JUMP: step_q <= uc.target;
				default: step_q <= STEP_IDLE;
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= KP_GAIN_RST;
			kd_q   <= KD_GAIN_RST;
			amax_q <= ACCEL_MAX_RST;
			damp_q <= DAMPING_RST;
			vmax_q <= VEL_MAX_RST;
			dt_q   <= STEP_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KP_GAIN:   kp_q   <= cfg_data[15:0];
				REG_KD_GAIN:   kd_q   <= cfg_data[15:0];
				REG_ACCEL_MAX: amax_q <= cfg_data[14:0];
				REG_DAMPING:   damp_q <= cfg_data[14:0];
				REG_VEL_MAX:   vmax_q <= cfg_data[14:0];
				REG_STEP_TIME: dt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stored joint velocities, written once per item for an in-range joint.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_JOINTS; i++) begin
				vel_q[i] <= '0;
			end
		end else if (uc.op == OP_VEL && jvalid_q) begin
			vel_q[JIDX_W'(joint_q)] <= nv_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pos_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath registers driven by the control word.
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (uc.op)
			OP_LOAD: begin
				if (in_acc) begin
					joint_q  <= in_data.joint;
					jvalid_q <= load_valid;
					err_q    <= 17'(goal_w) - 17'(meas_w);
					meas_q   <= meas_w;
					v_q      <= load_valid ? vel_q[JIDX_W'(in_data.joint)] : 16'sd0;
				end
			end
			OP_ACC_LD:  acc_q <= prod_q[33:0];
			OP_ACC_SUB: acc_q <= acc_q - $signed(prod_q[33:0]);
			OP_ACLAMP: begin
				if (acc_q > amax20) begin
					acc_lim_q <= $signed({1'b0, amax_q});
					alim_q    <= 1'b1;
				end else if (acc_q < -amax20) begin
					acc_lim_q <= -$signed({1'b0, amax_q});
					alim_q    <= 1'b1;
				end else begin
					acc_lim_q <= acc_q[23:8];
					alim_q    <= 1'b0;
				end
			end
			OP_DIFF: acc_q <= (34'(acc_lim_q) <<< 12) - $signed(prod_q[33:0]);
			OP_VEL: begin
				nv_q   <= nv_d;
				vlim_q <= vlim_d;
			end
			OP_POS: begin
				if (pos_fire) begin
					out_q.joint_out     <= joint_q;
					out_q.next_position <= pos_d;
					out_q.next_velocity <= nv_q;
					out_q.accel_limited <= alim_q;
					out_q.vel_limited   <= vlim_q;
				end
			end
			default: ;
		endcase
	end

	// An accepted item always moves the sequencer off the idle step.
	`PDJTL_ASSERT_NEXT(a_leave_idle, clk, arst_n, in_valid && !in_stall, step_q != STEP_IDLE)

	// A result appears only from the position step.
	`PDJTL_ASSERT_NOW(a_result_src, clk, arst_n, $rose(out_valid_q), $past(step_q) == STEP_POS)

	// A velocity-limited result carries exactly the limit.
	`PDJTL_ASSERT_NOW(a_vel_clamp, clk, arst_n, out_valid_q && out_q.vel_limited,
		out_q.next_velocity == $signed({1'b0, vmax_q}) || out_q.next_velocity == -$signed({1'b0, vmax_q}))

endmodule
